// ----- sv/chi_pkg.sv -----
package chi_pkg;

  // Field widths and fixed-point format.
  localparam int DATA_W = 32;
  localparam int FRAC_BITS = 16;
  localparam int WIDE_W = 64;
  localparam int DIFF_W = DATA_W + 1;
  localparam int DVS_W = DATA_W;
  localparam int QW = DATA_W + FRAC_BITS;

  // Pipeline shape.
  localparam int DIV_STEP = 4;
  localparam int DIV_STAGES = (QW + DIV_STEP - 1) / DIV_STEP;
  localparam int MUL_LAT = 4;
  localparam int K_T = DIV_STAGES;
  localparam int K1 = K_T + 1;
  localparam int K2 = K1 + MUL_LAT;
  localparam int K3 = K2 + MUL_LAT;
  localparam int K4 = K3 + MUL_LAT;
  localparam int LAST = K4 + 3;

  // Internal arithmetic limits.
  localparam logic signed [WIDE_W-1:0] MAX_W = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] MIN_W = {1'b1, {(WIDE_W-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] ONE = WIDE_W'(1) <<< FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] THREE = ONE + ONE + ONE;
  localparam logic signed [WIDE_W-1:0] OUT_MAX = (WIDE_W'(1) <<< (DATA_W - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] OUT_MIN = -OUT_MAX - WIDE_W'(1);

  // Result status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EQUAL = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] knot_a;
    logic signed [DATA_W-1:0] knot_b;
    logic signed [DATA_W-1:0] value_a;
    logic signed [DATA_W-1:0] value_b;
    logic signed [DATA_W-1:0] slope_a;
    logic signed [DATA_W-1:0] slope_b;
    logic signed [DATA_W-1:0] query_point;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interp_value;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic sat;
    logic signed [WIDE_W-1:0] val;
  } sat_t;

  // One divider stage: partial remainder, dividend bits shifting out while
  // quotient bits shift in, and the divisor.
  typedef struct packed {
    logic [DVS_W-1:0] rem;
    logic [QW-1:0] work;
    logic [DVS_W-1:0] dvs;
  } div_st_t;

  // Data that travels alongside an item through the pipeline.
  typedef struct packed {
    logic signed [DIFF_W-1:0] u;
    logic signed [DIFF_W-1:0] v;
    logic [DVS_W-1:0] umag;
    logic [DVS_W-1:0] dmag;
    logic neg;
    logic eq;
    logic sat;
    logic signed [DATA_W-1:0] y0;
    logic signed [DATA_W-1:0] y1;
    logic signed [DATA_W-1:0] p0;
    logic signed [DATA_W-1:0] p1;
    logic signed [WIDE_W-1:0] t;
    logic signed [WIDE_W-1:0] s;
    logic signed [WIDE_W-1:0] a0;
    logic signed [WIDE_W-1:0] a1;
    logic signed [WIDE_W-1:0] acc;
    logic signed [WIDE_W-1:0] b;
    logic signed [WIDE_W-1:0] c;
    logic [1:0] status;
  } side_t;

  // Saturating add to the symmetric range of the wide word.
  function automatic sat_t add_sat(logic signed [WIDE_W-1:0] a,
                                   logic signed [WIDE_W-1:0] b);
    logic signed [WIDE_W:0] sum;
    sat_t r;
    sum = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
    r.sat = 1'b0;
    r.val = sum[WIDE_W-1:0];
    if (sum > $signed({MAX_W[WIDE_W-1], MAX_W})) begin
      r.sat = 1'b1;
      r.val = MAX_W;
    end else if (sum < -$signed({MAX_W[WIDE_W-1], MAX_W})) begin
      r.sat = 1'b1;
      r.val = -MAX_W;
    end
    return r;
  endfunction

  // Negation that maps the most negative value to the largest positive.
  function automatic logic signed [WIDE_W-1:0] neg_v(logic signed [WIDE_W-1:0] a);
    return (a == MIN_W) ? MAX_W : -a;
  endfunction

endpackage

// ----- sv/cubic_hermite_interpolator.sv -----
// Cubic Hermite interpolator, signed Q16.16. Each item carries two knots,
// the values and slopes there and a query point; the block returns the
// Hermite cubic at the query point, saturated to 32 bits. Status is 0 when
// the result is exact to the fixed-point rules, 1 for equal knots (value 0)
// and 2 when any intermediate or the result saturated. The pipeline takes
// one item per clock while the output is not stalled. It has one input
// stage, 12 divider stages of 4 quotient bits each, one weight stage, three
// rounds of 4-stage multipliers and three accumulation stages. A stalled
// output holds the whole pipeline, input included, until the result is taken.
module cubic_hermite_interpolator (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  chi_pkg::req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output chi_pkg::rsp_t rsp
);

  localparam int W = chi_pkg::WIDE_W;

  chi_pkg::side_t side [chi_pkg::LAST+1];
  chi_pkg::side_t side_next [chi_pkg::LAST+1];
  chi_pkg::side_t side_in;
  logic vld [chi_pkg::LAST+1];
  logic en;

  logic [chi_pkg::QW-1:0] quo;
  logic signed [W-1:0] m1a [2], m1b [2], m1p [2];
  logic signed [W-1:0] m2a [4], m2b [4], m2p [4];
  logic signed [W-1:0] m3a [4], m3b [4], m3p [4];
  logic m1s [2];
  logic m2s [4];
  logic m3s [4];

  assign en = !vld[chi_pkg::LAST] || rsp_ready;
  assign req_ready = en;

  // Input stage: differences, magnitudes and the equal-knot check.
  always_comb begin
    logic signed [chi_pkg::DIFF_W-1:0] d;
    d = {req.knot_b[chi_pkg::DATA_W-1], req.knot_b} - {req.knot_a[chi_pkg::DATA_W-1], req.knot_a};
    side_in = '0;
    side_in.u = {req.query_point[chi_pkg::DATA_W-1], req.query_point}
              - {req.knot_a[chi_pkg::DATA_W-1], req.knot_a};
    side_in.v = {req.query_point[chi_pkg::DATA_W-1], req.query_point}
              - {req.knot_b[chi_pkg::DATA_W-1], req.knot_b};
    side_in.umag = side_in.u[chi_pkg::DIFF_W-1] ?
                   chi_pkg::DVS_W'(-side_in.u) : chi_pkg::DVS_W'(side_in.u);
    side_in.dmag = d[chi_pkg::DIFF_W-1] ? chi_pkg::DVS_W'(-d) : chi_pkg::DVS_W'(d);
    side_in.neg = side_in.u[chi_pkg::DIFF_W-1] ^ d[chi_pkg::DIFF_W-1];
    side_in.eq = (d == '0);
    side_in.y0 = req.value_a;
    side_in.y1 = req.value_b;
    side_in.p0 = req.slope_a;
    side_in.p1 = req.slope_b;
  end

  chi_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend ({side[0].umag, {chi_pkg::FRAC_BITS{1'b0}}}),
    .divisor  (side[0].dmag),
    .quotient (quo)
  );

  // Multiplier rounds: t*t and s*s, then the four basis weights, then the
  // weights times values and slopes.
  assign m1a[0] = side[chi_pkg::K1].t;
  assign m1b[0] = side[chi_pkg::K1].t;
  assign m1a[1] = side[chi_pkg::K1].s;
  assign m1b[1] = side[chi_pkg::K1].s;

  assign m2a[0] = side[chi_pkg::K2].a0;
  assign m2b[0] = m1p[1];
  assign m2a[1] = side[chi_pkg::K2].a1;
  assign m2b[1] = m1p[0];
  assign m2a[2] = W'(side[chi_pkg::K2].u);
  assign m2b[2] = m1p[1];
  assign m2a[3] = W'(side[chi_pkg::K2].v);
  assign m2b[3] = m1p[0];

  assign m3a[0] = W'(side[chi_pkg::K3].y0);
  assign m3b[0] = m2p[0];
  assign m3a[1] = W'(side[chi_pkg::K3].y1);
  assign m3b[1] = m2p[1];
  assign m3a[2] = W'(side[chi_pkg::K3].p0);
  assign m3b[2] = m2p[2];
  assign m3a[3] = W'(side[chi_pkg::K3].p1);
  assign m3b[3] = m2p[3];

  for (genvar g = 0; g < 2; g++) begin : g_m1
    chi_mul u_mul (.clk(clk), .en(en), .a(m1a[g]), .b(m1b[g]), .p(m1p[g]), .sat(m1s[g]));
  end
  for (genvar g = 0; g < 4; g++) begin : g_m2
    chi_mul u_mul (.clk(clk), .en(en), .a(m2a[g]), .b(m2b[g]), .p(m2p[g]), .sat(m2s[g]));
  end
  for (genvar g = 0; g < 4; g++) begin : g_m3
    chi_mul u_mul (.clk(clk), .en(en), .a(m3a[g]), .b(m3b[g]), .p(m3p[g]), .sat(m3s[g]));
  end

  // Per-stage updates of the data that travels with each item.
  always_comb begin
    logic signed [W-1:0] tq;
    chi_pkg::sat_t r_s, r_tt, r_a0, r_a1, r_y;
    side_next[0] = side_in;
    for (int i = 1; i <= chi_pkg::LAST; i++) begin
      side_next[i] = side[i-1];
    end

    // Weight stage: t, 1-t, 1+2t and 3-2t.
    tq = W'(quo);
    if (side[chi_pkg::K_T].neg) begin
      tq = -tq;
    end
    r_s = chi_pkg::add_sat(chi_pkg::ONE, chi_pkg::neg_v(tq));
    r_tt = chi_pkg::add_sat(tq, tq);
    r_a0 = chi_pkg::add_sat(chi_pkg::ONE, r_tt.val);
    r_a1 = chi_pkg::add_sat(chi_pkg::THREE, chi_pkg::neg_v(r_tt.val));
    side_next[chi_pkg::K1].t = tq;
    side_next[chi_pkg::K1].s = r_s.val;
    side_next[chi_pkg::K1].a0 = r_a0.val;
    side_next[chi_pkg::K1].a1 = r_a1.val;
    side_next[chi_pkg::K1].sat = side[chi_pkg::K_T].sat | r_s.sat | r_tt.sat
                               | r_a0.sat | r_a1.sat;

    // Saturation from the first two multiplier rounds.
    side_next[chi_pkg::K2+1].sat = side[chi_pkg::K2].sat | m1s[0] | m1s[1];
    side_next[chi_pkg::K3+1].sat = side[chi_pkg::K3].sat | m2s[0] | m2s[1] | m2s[2] | m2s[3];

    // Accumulate the four terms, one add per stage.
    r_y = chi_pkg::add_sat(m3p[0], m3p[1]);
    side_next[chi_pkg::K4+1].acc = r_y.val;
    side_next[chi_pkg::K4+1].b = m3p[2];
    side_next[chi_pkg::K4+1].c = m3p[3];
    side_next[chi_pkg::K4+1].sat = side[chi_pkg::K4].sat | m3s[0] | m3s[1] | m3s[2] | m3s[3]
                                 | r_y.sat;

    r_y = chi_pkg::add_sat(side[chi_pkg::K4+1].acc, side[chi_pkg::K4+1].b);
    side_next[chi_pkg::K4+2].acc = r_y.val;
    side_next[chi_pkg::K4+2].sat = side[chi_pkg::K4+1].sat | r_y.sat;

    // Final add, clamp to the output range and form the status.
    r_y = chi_pkg::add_sat(side[chi_pkg::K4+2].acc, side[chi_pkg::K4+2].c);
    side_next[chi_pkg::LAST].sat = side[chi_pkg::K4+2].sat | r_y.sat;
    if (r_y.val > chi_pkg::OUT_MAX) begin
      r_y.val = chi_pkg::OUT_MAX;
      side_next[chi_pkg::LAST].sat = 1'b1;
    end else if (r_y.val < chi_pkg::OUT_MIN) begin
      r_y.val = chi_pkg::OUT_MIN;
      side_next[chi_pkg::LAST].sat = 1'b1;
    end
    side_next[chi_pkg::LAST].acc = r_y.val;
    side_next[chi_pkg::LAST].status = side_next[chi_pkg::LAST].sat ? chi_pkg::ST_SAT
                                                                    : chi_pkg::ST_OK;
    if (side[chi_pkg::K4+2].eq) begin
      side_next[chi_pkg::LAST].acc = '0;
      side_next[chi_pkg::LAST].status = chi_pkg::ST_EQUAL;
    end
  end

  // Pipeline registers; valid bits move with the data.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= chi_pkg::LAST; i++) begin
        side[i] <= side_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= chi_pkg::LAST; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= req_valid;
      for (int i = 1; i <= chi_pkg::LAST; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  assign rsp_valid = vld[chi_pkg::LAST];
  assign rsp.interp_value = side[chi_pkg::LAST].acc[chi_pkg::DATA_W-1:0];
  assign rsp.status = side[chi_pkg::LAST].status;

  // An equal-knot item always comes out as zero.
  a_equal_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == chi_pkg::ST_EQUAL |-> rsp.interp_value == '0)
    else $error("equal-knot item with nonzero value");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == chi_pkg::ST_OK || rsp.status == chi_pkg::ST_EQUAL ||
                   rsp.status == chi_pkg::ST_SAT))
    else $error("undefined status code");

  // A waiting result blocks new items.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("item accepted while the output is stalled");

  // An accepted item enters the input stage.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> vld[0])
    else $error("accepted item lost at the input stage");

endmodule

// ----- sv/chi_div.sv -----
module chi_div (
  input  logic clk,
  input  logic en,
  input  logic [chi_pkg::QW-1:0] dividend,
  input  logic [chi_pkg::DVS_W-1:0] divisor,
  output logic [chi_pkg::QW-1:0] quotient
);

  chi_pkg::div_st_t st [chi_pkg::DIV_STAGES];
  chi_pkg::div_st_t st_next [chi_pkg::DIV_STAGES];

  // Restoring division, four quotient bits per stage.
  always_comb begin
    chi_pkg::div_st_t cur;
    logic [chi_pkg::DVS_W:0] trial;
    logic qb;
    for (int k = 0; k < chi_pkg::DIV_STAGES; k++) begin
      if (k == 0) begin
        cur.rem = '0;
        cur.work = dividend;
        cur.dvs = divisor;
      end else begin
        cur = st[k-1];
      end
      for (int j = 0; j < chi_pkg::DIV_STEP; j++) begin
        trial = {cur.rem, cur.work[chi_pkg::QW-1]};
        qb = (trial >= {1'b0, cur.dvs});
        if (qb) begin
          trial = trial - {1'b0, cur.dvs};
        end
        cur.rem = trial[chi_pkg::DVS_W-1:0];
        cur.work = {cur.work[chi_pkg::QW-2:0], qb};
      end
      st_next[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < chi_pkg::DIV_STAGES; k++) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign quotient = st[chi_pkg::DIV_STAGES-1].work;

endmodule

// ----- sv/chi_mul.sv -----
module chi_mul (
  input  logic clk,
  input  logic en,
  input  logic signed [chi_pkg::WIDE_W-1:0] a,
  input  logic signed [chi_pkg::WIDE_W-1:0] b,
  output logic signed [chi_pkg::WIDE_W-1:0] p,
  output logic sat
);

  localparam int HW = chi_pkg::WIDE_W / 2;
  localparam int PW = 2 * chi_pkg::WIDE_W;

  logic [chi_pkg::WIDE_W-1:0] ma, mb;
  logic neg1, neg2, neg3;
  logic [chi_pkg::WIDE_W-1:0] ll, lh, hl, hh;
  logic [PW-1:0] prod;
  logic [PW-1:0] shifted;
  logic over;
  logic [chi_pkg::WIDE_W-1:0] mag_r;

  // Stage one: magnitudes and the sign of the product.
  // Stage two: four half-width partial products.
  // Stage three: the exact double-width product.
  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[chi_pkg::WIDE_W-1] ^ b[chi_pkg::WIDE_W-1];
      ma <= a[chi_pkg::WIDE_W-1] ? -a : a;
      mb <= b[chi_pkg::WIDE_W-1] ? -b : b;
      neg2 <= neg1;
      ll <= chi_pkg::WIDE_W'(ma[HW-1:0]) * chi_pkg::WIDE_W'(mb[HW-1:0]);
      lh <= chi_pkg::WIDE_W'(ma[HW-1:0]) * chi_pkg::WIDE_W'(mb[chi_pkg::WIDE_W-1:HW]);
      hl <= chi_pkg::WIDE_W'(ma[chi_pkg::WIDE_W-1:HW]) * chi_pkg::WIDE_W'(mb[HW-1:0]);
      hh <= chi_pkg::WIDE_W'(ma[chi_pkg::WIDE_W-1:HW])
          * chi_pkg::WIDE_W'(mb[chi_pkg::WIDE_W-1:HW]);
      neg3 <= neg2;
      prod <= {hh, ll} + ({{HW{1'b0}}, lh, {HW{1'b0}}}) + ({{HW{1'b0}}, hl, {HW{1'b0}}});
    end
  end

  // Stage four: scale back, saturate the magnitude, apply the sign.
  assign shifted = prod >> chi_pkg::FRAC_BITS;
  assign over = |shifted[PW-1:chi_pkg::WIDE_W-1];
  assign mag_r = over ? chi_pkg::MAX_W : shifted[chi_pkg::WIDE_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= over;
      p <= neg3 ? -mag_r : mag_r;
    end
  end

endmodule

// ----- verif/tb_cubic_hermite_interpolator.sv -----
module tb_cubic_hermite_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_TAIL = 150;
  localparam logic signed [63:0] BIG = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMALLEST = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] UNIT = 32'sd1 <<< chi_pkg::FRAC_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  chi_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  chi_pkg::rsp_t rsp;

  chi_pkg::req_t pending_reqs[$];
  chi_pkg::rsp_t interp_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit stimulus_done = 1'b0;

  cubic_hermite_interpolator uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #4 clk = ~clk;

  // Saturating add to the symmetric range of the 64-bit word.
  function automatic logic signed [63:0] sum_sat(logic signed [63:0] a, logic signed [63:0] b,
                                                  inout bit sat);
    logic signed [64:0] total;
    total = 65'(a) + 65'(b);
    if (total > 65'(BIG)) begin
      sat = 1'b1;
      return BIG;
    end else if (total < -65'(BIG)) begin
      sat = 1'b1;
      return -BIG;
    end
    return total[63:0];
  endfunction

  function automatic logic signed [63:0] negate(logic signed [63:0] a);
    return (a == SMALLEST) ? BIG : -a;
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // Fixed-point product: exact magnitude product, scaled down, clamped, signed.
  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b,
                                                 inout bit sat);
    logic [127:0] full;
    logic [127:0] scaled;
    logic [63:0] m;
    full = 128'(magnitude(a)) * 128'(magnitude(b));
    scaled = full >> chi_pkg::FRAC_BITS;
    if (scaled > 128'(BIG)) begin
      sat = 1'b1;
      m = 64'(BIG);
    end else begin
      m = scaled[63:0];
    end
    return (a[63] != b[63]) ? -$signed(m) : $signed(m);
  endfunction

  // Hermite cubic at the query point, under the block's fixed-point rules.
  // Each saturating step stands alone so that its flag is never lost.
  function automatic chi_pkg::rsp_t hermite_value(chi_pkg::req_t r);
    logic signed [63:0] d, u, v, t, s, t2, s2, tt, h0, h1, g0, g1, y;
    logic signed [63:0] w0, w1, term;
    logic [63:0] q;
    bit sat;
    chi_pkg::rsp_t o;
    sat = 1'b0;
    d = 64'(r.knot_b) - 64'(r.knot_a);
    u = 64'(r.query_point) - 64'(r.knot_a);
    v = 64'(r.query_point) - 64'(r.knot_b);
    if (d == 0) begin
      o.interp_value = '0;
      o.status = chi_pkg::ST_EQUAL;
      return o;
    end
    q = (magnitude(u) << chi_pkg::FRAC_BITS) / magnitude(d);
    t = (u[63] != d[63]) ? -$signed(q) : $signed(q);
    s = sum_sat(64'(UNIT), negate(t), sat);
    t2 = fx_mul(t, t, sat);
    s2 = fx_mul(s, s, sat);
    tt = sum_sat(t, t, sat);
    w0 = sum_sat(64'(UNIT), tt, sat);
    h0 = fx_mul(w0, s2, sat);
    w1 = sum_sat(64'(3 * UNIT), negate(tt), sat);
    h1 = fx_mul(w1, t2, sat);
    g0 = fx_mul(u, s2, sat);
    g1 = fx_mul(v, t2, sat);
    y = fx_mul(64'(r.value_a), h0, sat);
    term = fx_mul(64'(r.value_b), h1, sat);
    y = sum_sat(y, term, sat);
    term = fx_mul(64'(r.slope_a), g0, sat);
    y = sum_sat(y, term, sat);
    term = fx_mul(64'(r.slope_b), g1, sat);
    y = sum_sat(y, term, sat);
    if (y > 64'sh7FFF_FFFF) begin
      y = 64'sh7FFF_FFFF;
      sat = 1'b1;
    end
    if (y < -64'sh8000_0000) begin
      y = -64'sh8000_0000;
      sat = 1'b1;
    end
    o.interp_value = y[31:0];
    o.status = sat ? chi_pkg::ST_SAT : chi_pkg::ST_OK;
    return o;
  endfunction

  // Signed value spread over +-2^(bits-1).
  function automatic logic signed [31:0] spread(int bits);
    logic [31:0] raw;
    raw = $urandom;
    return $signed(raw >> (32 - bits)) - $signed(32'd1 << (bits - 1));
  endfunction

  function automatic chi_pkg::req_t make_item(logic signed [31:0] x0, logic signed [31:0] x1,
                                              logic signed [31:0] y0, logic signed [31:0] y1,
                                              logic signed [31:0] p0, logic signed [31:0] p1,
                                              logic signed [31:0] x);
    chi_pkg::req_t r;
    r.knot_a = x0;
    r.knot_b = x1;
    r.value_a = y0;
    r.value_b = y1;
    r.slope_a = p0;
    r.slope_b = p1;
    r.query_point = x;
    return r;
  endfunction

  // Random item: mostly well-behaved segments, some full-range noise.
  function automatic chi_pkg::req_t random_item();
    chi_pkg::req_t r;
    logic signed [31:0] lo, hi;
    int kind;
    kind = $urandom_range(0, 9);
    lo = spread(24);
    hi = lo + $signed($urandom_range(1, 32'h0040_0000));
    if ($urandom_range(0, 1)) begin
      r = make_item(hi, lo, spread(24), spread(24), spread(20), spread(20), '0);
    end else begin
      r = make_item(lo, hi, spread(24), spread(24), spread(20), spread(20), '0);
    end
    if (kind < 5) begin
      r.query_point = lo + $signed($urandom_range(0, 32'(hi - lo)));
    end else if (kind == 5) begin
      r.query_point = ($urandom_range(0, 1) ? r.knot_a : r.knot_b) + spread(4);
    end else if (kind == 6) begin
      r.query_point = lo + spread(26);
    end else if (kind == 7) begin
      r.knot_b = ($urandom_range(0, 3) == 0) ? r.knot_a : r.knot_a + spread(3);
      r.query_point = r.knot_a + spread(20);
    end else begin
      r = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    return r;
  endfunction

  // Build the item list, release reset, then wait for the block to drain.
  initial begin
    logic signed [31:0] mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    pending_reqs.push_back(make_item(0, UNIT, UNIT, 2 * UNIT, 0, 0, UNIT / 2));
    pending_reqs.push_back(make_item(0, UNIT, UNIT, 2 * UNIT, UNIT, -UNIT, 0));
    pending_reqs.push_back(make_item(0, UNIT, UNIT, 2 * UNIT, UNIT, -UNIT, UNIT));
    pending_reqs.push_back(make_item(5 * UNIT, 5 * UNIT, UNIT, UNIT, UNIT, UNIT, UNIT));
    pending_reqs.push_back(make_item(mx, mx, mx, mx, mx, mx, mx));
    pending_reqs.push_back(make_item(mn, mn, mn, mn, mn, mn, mn));
    pending_reqs.push_back(make_item(mn, mx, mx, mn, mx, mn, 0));
    pending_reqs.push_back(make_item(mn, mx, mx, mx, mx, mx, mx));
    pending_reqs.push_back(make_item(mx, mn, mn, mx, mn, mx, mn));
    pending_reqs.push_back(make_item(0, 1, mx, mn, mx, mn, mx));
    pending_reqs.push_back(make_item(0, 1, mn, mn, mn, mn, mn));
    pending_reqs.push_back(make_item(2 * UNIT, -2 * UNIT, 3 * UNIT, -UNIT, UNIT, UNIT, UNIT));
    pending_reqs.push_back(make_item(0, UNIT, mx, mx, 0, 0, UNIT / 2));
    pending_reqs.push_back(make_item(0, UNIT, mn, mn, 0, 0, UNIT / 4));
    pending_reqs.push_back(make_item(0, UNIT, 0, 0, mx, mx, 3 * UNIT));
    pending_reqs.push_back(make_item(-1, 0, -1, -1, -1, -1, -1));
    pending_reqs.push_back(make_item(0, 4 * UNIT, UNIT, UNIT, 0, 0, 20 * UNIT));
    pending_reqs.push_back(make_item(-UNIT, UNIT, 0, UNIT, mx, 0, -UNIT));
    pending_reqs.push_back(make_item(0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pending_reqs.push_back(random_item());
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && !req_valid && interp_results.size() == 0);
    stimulus_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && interp_results.size() == 0) begin
      $display("PASS cubic_hermite_interpolator");
    end else begin
      $display("FAIL cubic_hermite_interpolator");
    end
    $finish;
  end

  // Driver: hold an item until accepted, with random bursts of idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        interp_results.push_back(hermite_value(req));
      end
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            send_gap <= $urandom_range(1, 13);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall bursts on the result side, then compare each item.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (interp_results.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d", $time,
                   rsp.interp_value, rsp.status);
          errors++;
        end else begin
          chi_pkg::rsp_t want;
          want = interp_results.pop_front();
          if (rsp.interp_value !== want.interp_value) begin
            $display("%0t: interp_value expected %h actual %h", $time,
                     want.interp_value, rsp.interp_value);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_ready <= 1'b0;
      end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 12);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || stimulus_done || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL cubic_hermite_interpolator");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
sv/chi_pkg.sv
sv/chi_div.sv
sv/chi_mul.sv
sv/cubic_hermite_interpolator.sv
verif/tb_cubic_hermite_interpolator.sv
